### rtl/assert_macros.svh
// Assertion macros shared by the housekeeping controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/thc_pkg.sv
// Shared constants, types and functions of the tick housekeeping controller.
package thc_pkg;

    // Tick timing
    localparam int TICK_RATE      = 100;
    localparam int DEBOUNCE_TICKS = 4;
    localparam int MINUTE_TICKS   = 6000;

    // Beat field widths
    localparam int KEY_W  = 3;
    localparam int SECS_W = 8;
    localparam int QUAL_W = 7;

    // Hold thresholds in debounced samples
    localparam int HOLD_SHORT = TICK_RATE / DEBOUNCE_TICKS;
    localparam int HOLD_MID   = TICK_RATE * 2 / DEBOUNCE_TICKS;
    localparam int HOLD_LONG  = TICK_RATE * 4 / DEBOUNCE_TICKS;

    // Counter widths
    localparam int HOLD_W   = $clog2(HOLD_LONG + 2);
    localparam int STABLE_W = $clog2(DEBOUNCE_TICKS + 2);
    localparam int MINUTE_W = $clog2(MINUTE_TICKS + 1);
    localparam int RATE_W   = $clog2(TICK_RATE + 1);
    localparam int PUMP_W   = 16;
    localparam int BEEP_W   = 8;
    localparam int IR_W     = 3;
    localparam int SIG_W    = 8;
    localparam int LOAD_W   = (RATE_W + SECS_W > PUMP_W) ? RATE_W + SECS_W : PUMP_W + 1;

    // Timer constants
    localparam logic [BEEP_W-1:0] BEEP_RESET     = BEEP_W'(100);
    localparam logic [BEEP_W-1:0] BEEP_MID_COUNT = BEEP_W'(5);
    localparam logic [BEEP_W-1:0] BEEP_LONG_COUNT = BEEP_W'(1);
    localparam logic [PUMP_W-1:0] PUMP_MAX       = {PUMP_W{1'b1}};
    localparam logic [SIG_W-1:0]  SIG_DUTY_RESET = SIG_W'(10);
    localparam logic [IR_W-1:0]   IR_DUTY_MAX    = IR_W'(4);
    localparam logic [IR_W-1:0]   IR_PHASE_LAST  = IR_W'(4);

    // Key handling events toward the timers
    typedef struct packed {
        logic              beep_load;
        logic [BEEP_W-1:0] beep_count;
        logic              query;
        logic              key_led;
        logic              wait_led;
    } t_key_stat;

    // Timer and PWM results of one tick
    typedef struct packed {
        logic beeper_on;
        logic pump_on;
        logic ir_led_on;
        logic signal_led_level;
        logic query;
    } t_timer_res;

    // Map modem signal quality to the signal LED duty
    function automatic logic [SIG_W-1:0] quality_duty(input logic [QUAL_W-1:0] q);
        logic [QUAL_W-1:0]   d;
        logic [QUAL_W+3:0]   prod;
        d    = q - QUAL_W'(10);
        prod = {4'b0, d} * (QUAL_W+4)'(15);
        if (q < QUAL_W'(12)) begin
            quality_duty = SIG_W'(1);
        end else if (q > QUAL_W'(24)) begin
            quality_duty = SIG_W'(255);
        end else begin
            quality_duty = prod[SIG_W-1:0];
        end
    endfunction

endpackage

### rtl/thc_tick_if.sv
// Input channel carrying one housekeeping tick per beat.
interface thc_tick_if import thc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  key_levels;
    logic              pump_start;
    logic [SECS_W-1:0] pump_seconds;
    logic              ir_step;
    logic              modem_idle;
    logic [QUAL_W-1:0] signal_quality;

    modport source (
        output valid, key_levels, pump_start, pump_seconds, ir_step, modem_idle,
               signal_quality,
        input  ready
    );
    modport sink (
        input  valid, key_levels, pump_start, pump_seconds, ir_step, modem_idle,
               signal_quality,
        output ready
    );
endinterface

### rtl/thc_result_if.sv
// Output channel carrying the drive levels produced by one tick.
interface thc_result_if ();
    logic valid;
    logic ready;
    logic beeper_on;
    logic pump_on;
    logic ir_led_on;
    logic key_led_on;
    logic wait_led_on;
    logic signal_led_level;
    logic quality_query;

    modport source (
        output valid, beeper_on, pump_on, ir_led_on, key_led_on, wait_led_on,
               signal_led_level, quality_query,
        input  ready
    );
    modport sink (
        input  valid, beeper_on, pump_on, ir_led_on, key_led_on, wait_led_on,
               signal_led_level, quality_query,
        output ready
    );
endinterface

### rtl/thc_keys.sv
// Key debounce, two-key hold timing, key LED and waiting flag.
`include "assert_macros.svh"

module thc_keys import thc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [KEY_W-1:0] i_key_levels,
    output t_key_stat        o_stat
);

    logic [KEY_W-1:0]    r_prev,   n_prev;
    logic [STABLE_W-1:0] r_stable, n_stable;
    logic [HOLD_W-1:0]   r_hold,   n_hold;
    logic                r_led,    n_led;
    logic                r_wait,   n_wait;
    logic [HOLD_W-1:0]   w_hold_inc;

    assign w_hold_inc = r_hold + HOLD_W'(1);

    // Debounce the keys and run the hold timer on each settled sample
    always_comb begin
        n_prev            = r_prev;
        n_stable          = r_stable;
        n_hold            = r_hold;
        n_led             = r_led;
        n_wait            = r_wait;
        o_stat.beep_load  = 1'b0;
        o_stat.beep_count = BEEP_MID_COUNT;
        o_stat.query      = 1'b0;
        if (i_key_levels == r_prev) begin
            n_stable = r_stable + STABLE_W'(1);
            if (r_stable + STABLE_W'(1) > STABLE_W'(DEBOUNCE_TICKS)) begin
                n_stable = '0;
                if (i_key_levels[1:0] == 2'b00) begin
                    n_hold = w_hold_inc;
                    if (w_hold_inc > HOLD_W'(HOLD_LONG)) begin
                        n_hold = '0;
                    end else if (w_hold_inc > HOLD_W'(HOLD_MID)) begin
                        o_stat.beep_load  = 1'b1;
                        o_stat.beep_count = BEEP_LONG_COUNT;
                        if (!w_hold_inc[0]) begin
                            n_led = ~r_led;
                        end
                        n_wait = 1'b1;
                    end else if (w_hold_inc > HOLD_W'(HOLD_SHORT)) begin
                        o_stat.beep_load  = 1'b1;
                        o_stat.beep_count = BEEP_MID_COUNT;
                    end
                end else begin
                    n_hold = '0;
                    n_led  = 1'b0;
                end
                o_stat.query = ~i_key_levels[2];
            end
        end else begin
            n_prev   = i_key_levels;
            n_stable = '0;
        end
        o_stat.key_led  = n_led;
        o_stat.wait_led = n_wait;
    end

    // Advance key state once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_stable <= '0;
            r_hold   <= '0;
            r_led    <= 1'b0;
            r_wait   <= 1'b0;
        end else if (i_step) begin
            r_prev   <= n_prev;
            r_stable <= n_stable;
            r_hold   <= n_hold;
            r_led    <= n_led;
            r_wait   <= n_wait;
        end
    end

    `ASSERT_NEXT(a_wait_sticky, i_clk, i_rst_n, r_wait, r_wait, "waiting flag dropped")
    `ASSERT_ALWAYS(a_hold_bound, i_clk, i_rst_n, r_hold <= HOLD_W'(HOLD_LONG),
        "hold count above wrap point")
    `ASSERT_ALWAYS(a_stable_bound, i_clk, i_rst_n, r_stable <= STABLE_W'(DEBOUNCE_TICKS),
        "debounce count above limit")

endmodule

### rtl/thc_timers.sv
// Minute timer, beeper and pump countdowns, IR and signal LED PWM.
`include "assert_macros.svh"

module thc_timers import thc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_pump_start,
    input  logic [SECS_W-1:0] i_pump_seconds,
    input  logic              i_ir_step,
    input  logic              i_modem_idle,
    input  logic [QUAL_W-1:0] i_signal_quality,
    input  t_key_stat         i_key,
    output t_timer_res        o_res
);

    logic [MINUTE_W-1:0] r_minute, n_minute;
    logic [BEEP_W-1:0]   r_beep,   n_beep;
    logic                r_beep_level, n_beep_level;
    logic [PUMP_W-1:0]   r_pump,   n_pump;
    logic                r_pump_level, n_pump_level;
    logic [IR_W-1:0]     r_ir_duty,  n_ir_duty;
    logic [IR_W-1:0]     r_ir_phase, n_ir_phase;
    logic [SIG_W-1:0]    r_sig_duty,  n_sig_duty;
    logic [SIG_W-1:0]    r_sig_phase, n_sig_phase;
    logic [LOAD_W-1:0]   w_load;
    logic [PUMP_W-1:0]   w_pump_cur;
    logic [IR_W-1:0]     w_ir_inc;
    logic                w_minute_query;

    assign w_load = LOAD_W'(TICK_RATE) * LOAD_W'(i_pump_seconds);

    // Start the pump only when it is stopped, then count it down
    always_comb begin
        w_pump_cur = r_pump;
        if (i_pump_start && r_pump == '0) begin
            w_pump_cur = (w_load > LOAD_W'(PUMP_MAX)) ? PUMP_MAX : w_load[PUMP_W-1:0];
        end
        n_pump       = w_pump_cur;
        n_pump_level = r_pump_level;
        if (w_pump_cur != '0) begin
            n_pump       = w_pump_cur - PUMP_W'(1);
            n_pump_level = (w_pump_cur != PUMP_W'(1));
        end
    end

    // Count the beeper down; key holds reload it afterward
    always_comb begin
        n_beep       = r_beep;
        n_beep_level = r_beep_level;
        if (r_beep != '0) begin
            n_beep       = r_beep - BEEP_W'(1);
            n_beep_level = (r_beep != BEEP_W'(1));
        end
        if (i_key.beep_load) begin
            n_beep = i_key.beep_count;
        end
    end

    // Sample signal quality once a minute while the modem is idle
    always_comb begin
        n_minute       = r_minute + MINUTE_W'(1);
        n_sig_duty     = r_sig_duty;
        w_minute_query = 1'b0;
        if (r_minute >= MINUTE_W'(MINUTE_TICKS)) begin
            n_minute = '0;
            if (i_modem_idle) begin
                n_sig_duty     = quality_duty(i_signal_quality);
                w_minute_query = 1'b1;
            end
        end
    end

    // Step the IR duty and run both PWM phases
    assign n_ir_duty   = i_ir_step ? ((r_ir_duty >= IR_DUTY_MAX) ? '0 : r_ir_duty + IR_W'(1))
                                   : r_ir_duty;
    assign w_ir_inc    = r_ir_phase + IR_W'(1);
    assign n_ir_phase  = (w_ir_inc >= IR_PHASE_LAST) ? '0 : w_ir_inc;
    assign n_sig_phase = r_sig_phase + SIG_W'(1);

    assign o_res.beeper_on        = n_beep_level;
    assign o_res.pump_on          = n_pump_level;
    assign o_res.ir_led_on        = (w_ir_inc <= n_ir_duty);
    assign o_res.signal_led_level = (n_sig_phase > n_sig_duty);
    assign o_res.query            = w_minute_query | i_key.query;

    // Advance timers once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute     <= '0;
            r_beep       <= BEEP_RESET;
            r_beep_level <= 1'b0;
            r_pump       <= '0;
            r_pump_level <= 1'b0;
            r_ir_duty    <= '0;
            r_ir_phase   <= '0;
            r_sig_duty   <= SIG_DUTY_RESET;
            r_sig_phase  <= '0;
        end else if (i_step) begin
            r_minute     <= n_minute;
            r_beep       <= n_beep;
            r_beep_level <= n_beep_level;
            r_pump       <= n_pump;
            r_pump_level <= n_pump_level;
            r_ir_duty    <= n_ir_duty;
            r_ir_phase   <= n_ir_phase;
            r_sig_duty   <= n_sig_duty;
            r_sig_phase  <= n_sig_phase;
        end
    end

    `ASSERT_ALWAYS(a_pump_level, i_clk, i_rst_n, !r_pump_level || r_pump != '0,
        "pump driven with no time left")
    `ASSERT_ALWAYS(a_ir_range, i_clk, i_rst_n,
        r_ir_duty <= IR_DUTY_MAX && r_ir_phase < IR_PHASE_LAST, "IR PWM state out of range")
    `ASSERT_ALWAYS(a_minute_range, i_clk, i_rst_n, r_minute <= MINUTE_W'(MINUTE_TICKS),
        "minute timer past its period")

endmodule

### rtl/tick_housekeeping_controller.sv
// Top level of the tick housekeeping controller.
//
// Usage: send one beat on i_tick per periodic system tick. Each beat carries
// the three active-low key levels, an optional pump start with its run time
// in seconds, an optional IR duty step, and the modem idle flag with the last
// signal quality. For every input beat exactly one beat leaves on o_result
// with the beeper, pump, IR LED, key LED, waiting LED and signal LED levels
// and the quality query request of that tick.
// Flow: an accepted tick sits in the input register until the result register
// is free and then loads into it. Throughput: one tick per cycle while
// o_result is ready; both sides of the block hold one beat each, so a new
// tick is taken while a result waits.
// Stall: while o_result is not ready the result is held and one more tick
// waits in the input register; i_tick.ready drops only when both are full.
// Reset: synchronous, active low; all timers, PWM phases and key state take
// their power-on values (beeper count 100, signal duty 10, the rest zero)
// and both channels come up empty.
`include "assert_macros.svh"

module tick_housekeeping_controller import thc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thc_tick_if.sink    i_tick,
    thc_result_if.source o_result
);

    typedef struct packed {
        logic [KEY_W-1:0]  key_levels;
        logic              pump_start;
        logic [SECS_W-1:0] pump_seconds;
        logic              ir_step;
        logic              modem_idle;
        logic [QUAL_W-1:0] signal_quality;
    } t_tick;

    logic       r_in_valid;
    t_tick      r_tick;
    logic       r_out_valid;
    t_timer_res r_res;
    logic       r_key_led;
    logic       r_wait_led;
    logic       w_adv;
    logic       w_take;
    t_key_stat  w_key;
    t_timer_res w_res;

    // Process the held tick whenever the result register is free
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_adv;
    assign w_take       = i_tick.valid && i_tick.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tick.key_levels     <= i_tick.key_levels;
            r_tick.pump_start     <= i_tick.pump_start;
            r_tick.pump_seconds   <= i_tick.pump_seconds;
            r_tick.ir_step        <= i_tick.ir_step;
            r_tick.modem_idle     <= i_tick.modem_idle;
            r_tick.signal_quality <= i_tick.signal_quality;
        end
    end

    thc_keys u_keys (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_key_levels (r_tick.key_levels),
        .o_stat       (w_key)
    );

    thc_timers u_timers (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_adv),
        .i_pump_start     (r_tick.pump_start),
        .i_pump_seconds   (r_tick.pump_seconds),
        .i_ir_step        (r_tick.ir_step),
        .i_modem_idle     (r_tick.modem_idle),
        .i_signal_quality (r_tick.signal_quality),
        .i_key            (w_key),
        .o_res            (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res      <= w_res;
            r_key_led  <= w_key.key_led;
            r_wait_led <= w_key.wait_led;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.beeper_on        = r_res.beeper_on;
    assign o_result.pump_on          = r_res.pump_on;
    assign o_result.ir_led_on        = r_res.ir_led_on;
    assign o_result.key_led_on       = r_key_led;
    assign o_result.wait_led_on      = r_wait_led;
    assign o_result.signal_led_level = r_res.signal_led_level;
    assign o_result.quality_query    = r_res.query;

    `ASSERT_ALWAYS(a_no_take_when_full, i_clk, i_rst_n,
        !(r_in_valid && r_out_valid && !o_result.ready) || !i_tick.ready,
        "tick taken with both registers full")
    `ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid,
        "processed tick produced no result")
    `ASSERT_NEXT(a_take_fills_in, i_clk, i_rst_n, w_take, r_in_valid,
        "accepted tick lost from input register")

endmodule

### bench/thc_bench_pkg.sv
// Beat types and the drive-level tracker used by the housekeeping controller bench.
`timescale 1ns / 100ps

package thc_bench_pkg;
    import thc_pkg::*;

    // One tick beat as driven on the input channel
    typedef struct packed {
        logic [KEY_W-1:0]  key_levels;
        logic              pump_start;
        logic [SECS_W-1:0] pump_seconds;
        logic              ir_step;
        logic              modem_idle;
        logic [QUAL_W-1:0] signal_quality;
    } t_tick_beat;

    // Drive levels carried by one result beat
    typedef struct packed {
        logic beeper_on;
        logic pump_on;
        logic ir_led_on;
        logic key_led_on;
        logic wait_led_on;
        logic signal_led_level;
        logic quality_query;
    } t_drive_levels;

    // Tracks controller state per accepted tick and holds the levels still due
    class drive_level_board;
        t_drive_levels pending_levels[$];
        int            mismatches;
        int            beats_seen;

        bit [15:0] minute_count;
        bit [7:0]  beep_count;
        bit [15:0] pump_left;
        bit        beep_lvl;
        bit        pump_lvl;
        bit [2:0]  settled_keys;
        bit [7:0]  stable_count;
        bit [15:0] hold_count;
        bit        key_led;
        bit        wait_latch;
        bit [2:0]  ir_duty;
        bit [2:0]  ir_phase;
        bit [7:0]  sig_duty;
        bit [7:0]  sig_phase;

        function new();
            mismatches   = 0;
            beats_seen   = 0;
            minute_count = '0;
            beep_count   = BEEP_RESET;
            pump_left    = '0;
            beep_lvl     = 1'b0;
            pump_lvl     = 1'b0;
            settled_keys = '0;
            stable_count = '0;
            hold_count   = '0;
            key_led      = 1'b0;
            wait_latch   = 1'b0;
            ir_duty      = '0;
            ir_phase     = '0;
            sig_duty     = SIG_DUTY_RESET;
            sig_phase    = '0;
        endfunction

        // Advance the tracked state by one tick and return its drive levels
        function t_drive_levels next_levels(t_tick_beat t);
            t_drive_levels lv;
            int unsigned   load;
            bit            query;
            query = 1'b0;

            // Load the pump only when it is stopped
            if (t.pump_start && pump_left == 0) begin
                load      = TICK_RATE * int'(t.pump_seconds);
                pump_left = (load > 32'hFFFF) ? 16'hFFFF : load[15:0];
            end

            if (t.ir_step) begin
                ir_duty = (ir_duty >= IR_DUTY_MAX) ? 3'd0 : ir_duty + 3'd1;
            end

            // Minute timer: remap signal quality when the modem is free
            if (minute_count >= MINUTE_TICKS) begin
                minute_count = '0;
                if (t.modem_idle) begin
                    if (t.signal_quality < 12) begin
                        sig_duty = 8'd1;
                    end else if (t.signal_quality > 24) begin
                        sig_duty = 8'd255;
                    end else begin
                        sig_duty = 8'((int'(t.signal_quality) - 10) * 15);
                    end
                    query = 1'b1;
                end
            end else begin
                minute_count = minute_count + 16'd1;
            end

            // Count down timers; levels refresh only here
            if (beep_count != 0) begin
                beep_count = beep_count - 8'd1;
                beep_lvl   = (beep_count != 0);
            end
            if (pump_left != 0) begin
                pump_left = pump_left - 16'd1;
                pump_lvl  = (pump_left != 0);
            end

            // Debounce, then time the two-key hold
            if (t.key_levels == settled_keys) begin
                stable_count = stable_count + 8'd1;
                if (stable_count > DEBOUNCE_TICKS) begin
                    stable_count = '0;
                    if (t.key_levels[1:0] == 2'b00) begin
                        hold_count = hold_count + 16'd1;
                        if (hold_count > HOLD_LONG) begin
                            hold_count = '0;
                        end else if (hold_count > HOLD_MID) begin
                            beep_count = BEEP_LONG_COUNT;
                            if (!hold_count[0]) key_led = ~key_led;
                            wait_latch = 1'b1;
                        end else if (hold_count > HOLD_SHORT) begin
                            beep_count = BEEP_MID_COUNT;
                        end
                    end else begin
                        hold_count = '0;
                        key_led    = 1'b0;
                    end
                    if (!t.key_levels[2]) query = 1'b1;
                end
            end else begin
                settled_keys = t.key_levels;
                stable_count = '0;
            end

            // Software PWM outputs
            ir_phase     = ir_phase + 3'd1;
            lv.ir_led_on = (ir_phase <= ir_duty);
            if (ir_phase >= IR_PHASE_LAST) ir_phase = '0;
            sig_phase = sig_phase + 8'd1;

            lv.beeper_on        = beep_lvl;
            lv.pump_on          = pump_lvl;
            lv.key_led_on       = key_led;
            lv.wait_led_on      = wait_latch;
            lv.signal_led_level = (sig_phase > sig_duty);
            lv.quality_query    = query;
            return lv;
        endfunction

        function void note_tick(t_tick_beat t);
            pending_levels.push_back(next_levels(t));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", beats_seen, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic got, logic want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %b want %b", name, got, want));
            end
        endtask

        // Compare one result beat against the oldest pending levels
        task check_levels(t_drive_levels got);
            t_drive_levels want;
            if (pending_levels.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_levels.pop_front();
                compare_field("beeper_on", got.beeper_on, want.beeper_on);
                compare_field("pump_on", got.pump_on, want.pump_on);
                compare_field("ir_led_on", got.ir_led_on, want.ir_led_on);
                compare_field("key_led_on", got.key_led_on, want.key_led_on);
                compare_field("wait_led_on", got.wait_led_on, want.wait_led_on);
                compare_field("signal_led_level", got.signal_led_level,
                              want.signal_led_level);
                compare_field("quality_query", got.quality_query, want.quality_query);
            end
            beats_seen++;
        endtask
    endclass

endpackage

### bench/tb_tick_housekeeping_controller.sv
// Top of the housekeeping controller bench: clock, reset, tick driver and result sink.
`timescale 1ns / 100ps

module tb_tick_housekeeping_controller;
    import thc_pkg::*;
    import thc_bench_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int LIMIT        = 20 * RANDOM_ITEMS + 20000;
    localparam int CALM_FROM    = 800;
    localparam int CALM_TO      = 1400;
    localparam int IDLE_PCT     = 19;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    logic calm_stretch;

    drive_level_board board = new();

    thc_tick_if   tick_ch ();
    thc_result_if result_ch ();

    tick_housekeeping_controller DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always_ff @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hold both sides busy without gaps inside this window
    assign calm_stretch = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    // Offer one tick beat after a random gap and wait for it to be taken
    task automatic send_tick(input t_tick_beat beat);
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid          <= 1'b1;
        tick_ch.key_levels     <= beat.key_levels;
        tick_ch.pump_start     <= beat.pump_start;
        tick_ch.pump_seconds   <= beat.pump_seconds;
        tick_ch.ir_step        <= beat.ir_step;
        tick_ch.modem_idle     <= beat.modem_idle;
        tick_ch.signal_quality <= beat.signal_quality;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        board.note_tick(beat);
    endtask

    // Result sink with random back-pressure
    initial begin
        t_drive_levels seen;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                seen.beeper_on        = result_ch.beeper_on;
                seen.pump_on          = result_ch.pump_on;
                seen.ir_led_on        = result_ch.ir_led_on;
                seen.key_led_on       = result_ch.key_led_on;
                seen.wait_led_on      = result_ch.wait_led_on;
                seen.signal_led_level = result_ch.signal_led_level;
                seen.quality_query    = result_ch.quality_query;
                board.check_levels(seen);
            end
            result_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Timeout
    initial begin
        while (cycle_count <= LIMIT) @(posedge i_clk);
        $display("FAIL tick_housekeeping_controller");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        t_tick_beat       beat;
        logic [KEY_W-1:0] hold_keys;
        int               sent;
        int               run_len;
        int               kind;
        int               pick;
        bit               bounce;

        i_rst_n                = 1'b0;
        tick_ch.valid          = 1'b0;
        tick_ch.key_levels     = '1;
        tick_ch.pump_start     = 1'b0;
        tick_ch.pump_seconds   = '0;
        tick_ch.ir_step        = 1'b0;
        tick_ch.modem_idle     = 1'b0;
        tick_ch.signal_quality = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, ignored pump start, IR wrap, key 2, hold, bounce
        for (int n = 0; n < 22; n++) begin
            beat = '{key_levels: 3'b111, pump_start: 1'b0, pump_seconds: '0,
                     ir_step: 1'b0, modem_idle: 1'b1, signal_quality: '0};
            if (n == 0) begin
                beat.pump_start     = 1'b1;
                beat.pump_seconds   = 8'd255;
                beat.ir_step        = 1'b1;
                beat.signal_quality = 7'd127;
            end else if (n == 1) begin
                beat.pump_start   = 1'b1;
                beat.pump_seconds = 8'd1;
                beat.ir_step      = 1'b1;
                beat.modem_idle   = 1'b0;
            end else if (n < 7) begin
                beat.key_levels     = 3'b011;
                beat.ir_step        = 1'b1;
                beat.signal_quality = 7'(n * 5);
            end else if (n < 12) begin
                beat.key_levels = 3'b000;
            end else if (n < 17) begin
                beat.key_levels = n[0] ? 3'b111 : 3'b000;
            end else begin
                beat.key_levels     = 3'b100;
                beat.modem_idle     = 1'b0;
                beat.signal_quality = 7'd24;
            end
            send_tick(beat);
        end

        // Random: runs of key holds of every length, other stable keys, bounce
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind   = $urandom_range(0, 9);
            bounce = 1'b0;
            if (kind < 4) begin
                hold_keys = 3'($urandom_range(0, 1) << 2);
                pick      = $urandom_range(0, 9);
                if (pick < 3) run_len = $urandom_range(1, 140);
                else if (pick < 6) run_len = $urandom_range(140, 280);
                else if (pick < 9) run_len = $urandom_range(280, 520);
                else run_len = $urandom_range(520, 1100);
            end else if (kind < 7) begin
                hold_keys = 3'($urandom_range(1, 3) | ($urandom_range(0, 1) << 2));
                run_len   = $urandom_range(5, 60);
            end else if (kind == 7) begin
                hold_keys = 3'b011;
                run_len   = $urandom_range(5, 30);
            end else begin
                hold_keys = '1;
                bounce    = 1'b1;
                run_len   = $urandom_range(1, 25);
            end
            // Clip the last run to the item budget
            if (run_len > RANDOM_ITEMS - sent) run_len = RANDOM_ITEMS - sent;
            for (int k = 0; k < run_len; k++) begin
                beat.key_levels = bounce ? 3'($urandom_range(0, 7)) : hold_keys;
                beat.pump_start = ($urandom_range(0, 19) == 0);
                pick = $urandom_range(0, 49);
                if (pick < 40) beat.pump_seconds = 8'($urandom_range(0, 3));
                else if (pick < 49) beat.pump_seconds = 8'($urandom_range(4, 30));
                else beat.pump_seconds = 8'($urandom_range(0, 255));
                beat.ir_step    = ($urandom_range(0, 7) == 0);
                beat.modem_idle = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 7);
                if (pick < 2) beat.signal_quality = 7'($urandom_range(0, 11));
                else if (pick < 5) beat.signal_quality = 7'($urandom_range(12, 24));
                else if (pick < 7) beat.signal_quality = 7'($urandom_range(25, 99));
                else beat.signal_quality = 7'($urandom_range(100, 127));
                send_tick(beat);
                sent++;
            end
        end
        tick_ch.valid <= 1'b0;

        // Drain, then allow for the pipeline depth
        while (board.pending_levels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("PASS tick_housekeeping_controller");
        end else begin
            $display("FAIL tick_housekeeping_controller");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/thc_pkg.sv
rtl/thc_tick_if.sv
rtl/thc_result_if.sv
rtl/thc_keys.sv
rtl/thc_timers.sv
rtl/tick_housekeeping_controller.sv
bench/thc_bench_pkg.sv
bench/tb_tick_housekeeping_controller.sv
